FILE: rtl/core/bpl_pkg.sv
`default_nettype none

package bpl_pkg;

    // list capacity and derived widths
    localparam int Depth = 16;
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    // fixed port field widths
    localparam int CmdW  = 3;
    localparam int WordW = 32;
    localparam int PosW  = 8;
    localparam int StW   = 2;
    localparam int LenW  = 5;
    localparam int CmpW  = (PosW > CntW) ? PosW : CntW;

    typedef logic [CmdW-1:0]         t_cmd;
    typedef logic signed [WordW-1:0] t_word;
    typedef logic [PosW-1:0]         t_pos;
    typedef logic [StW-1:0]          t_st;
    typedef logic [LenW-1:0]         t_len;
    typedef logic [CntW-1:0]         t_cnt;
    typedef logic [AddrW-1:0]        t_addr;
    typedef logic [CmpW-1:0]         t_cmp;

    // command codes
    localparam t_cmd CmdInsFront = 3'd0;
    localparam t_cmd CmdInsPos   = 3'd1;
    localparam t_cmd CmdInsEnd   = 3'd2;
    localparam t_cmd CmdDelFront = 3'd3;
    localparam t_cmd CmdDelPos   = 3'd4;
    localparam t_cmd CmdDelEnd   = 3'd5;
    localparam t_cmd CmdClear    = 3'd6;
    localparam t_cmd CmdDump     = 3'd7;

    // status codes
    localparam t_st StOk       = 2'd0;
    localparam t_st StEmpty    = 2'd1;
    localparam t_st StNotFound = 2'd2;
    localparam t_st StFull     = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/core/bounded_positional_list.sv
// bounded_positional_list: ordered list of up to 16 signed 32-bit values
//
// input channel: i_in_valid / o_in_ready carry one request (command, value,
// position). output channel: o_out_valid / i_out_ready carry results
// (status, item_value, length, last). every request gives one result, except
// a dump of a non-empty list, which gives one result per element, front to
// back, with last set on the final one.
//
// the entries live in a one-port-read memory with registered read data, and
// a small sequencer moves them one at a time: each element shifted by an
// insert or delete is read, then written one place over; a dump reads the
// elements in turn. an insert ends by writing the new value into the gap, a
// delete starts by reading out the removed value. the block takes one request
// at a time and o_in_ready is high only while the sequencer is idle.
//
// results sit in an output register; when the receiver stalls, the
// sequencer holds at the step that produces the next result. a new request
// is taken while a finished result still waits there.
//
// reset empties the list (count zero) and drops any pending result; the
// entry memory itself is not cleared, only written entries are ever read.

`default_nettype none

module bounded_positional_list (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  bpl_pkg::t_cmd  i_command,
    input  wire  bpl_pkg::t_word i_value,
    input  wire  bpl_pkg::t_pos  i_position,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bpl_pkg::t_st         o_status,
    output bpl_pkg::t_word       o_item_value,
    output bpl_pkg::t_len        o_length,
    output logic                o_last
);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_RD   = 4'd1;  // read entry below the gap
    localparam logic [3:0] S_INS_WR   = 4'd2;  // move it one place back
    localparam logic [3:0] S_INS_PUT  = 4'd3;  // drop new value into the gap
    localparam logic [3:0] S_DEL_RD0  = 4'd4;  // read the victim
    localparam logic [3:0] S_DEL_CAP  = 4'd5;  // capture removed value
    localparam logic [3:0] S_DEL_RD   = 4'd6;  // read the next entry
    localparam logic [3:0] S_DEL_WR   = 4'd7;  // move it one place forward
    localparam logic [3:0] S_DEL_END  = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;  // single result waits here
    localparam logic [3:0] S_DMP_RD   = 4'd10;
    localparam logic [3:0] S_DMP_WAIT = 4'd11;

    logic [3:0]      r_state, n_state;
    bpl_pkg::t_cnt   r_count, n_count;
    bpl_pkg::t_cnt   r_ptr, n_ptr;   // moving element index
    bpl_pkg::t_cnt   r_idx, n_idx;   // insert or delete target index
    bpl_pkg::t_word  r_val, n_val;   // value to insert
    bpl_pkg::t_st    r_st, n_st;     // status of pending single result
    bpl_pkg::t_word  r_item, n_item; // item of pending single result

    // output register
    logic            r_out_valid, n_out_valid;
    bpl_pkg::t_st    r_o_status, n_o_status;
    bpl_pkg::t_word  r_o_item, n_o_item;
    bpl_pkg::t_len   r_o_length, n_o_length;
    logic            r_o_last, n_o_last;

    // entry memory
    bpl_pkg::t_word  r_mem [bpl_pkg::Depth];
    bpl_pkg::t_word  r_rdata;
    logic            rd_en;
    bpl_pkg::t_addr  rd_addr;
    logic            wr_en;
    bpl_pkg::t_addr  wr_addr;
    bpl_pkg::t_word  wr_data;

    logic            in_acc;
    logic            out_free;
    bpl_pkg::t_cnt   ptr_inc;
    bpl_pkg::t_cnt   ptr_dec;
    bpl_pkg::t_cmp   pos_c;
    bpl_pkg::t_cmp   cnt_c;

    assign o_in_ready   = (r_state == S_IDLE);
    assign in_acc       = i_in_valid && o_in_ready;
    assign out_free     = !r_out_valid || i_out_ready;
    assign ptr_inc      = r_ptr + bpl_pkg::t_cnt'(1);
    assign ptr_dec      = r_ptr - bpl_pkg::t_cnt'(1);
    assign pos_c        = bpl_pkg::t_cmp'(i_position);
    assign cnt_c        = bpl_pkg::t_cmp'(r_count);

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_item_value = r_o_item;
    assign o_length     = r_o_length;
    assign o_last       = r_o_last;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_val       = r_val;
        n_st        = r_st;
        n_item      = r_item;
        n_out_valid = r_out_valid && !i_out_ready;
        n_o_status  = r_o_status;
        n_o_item    = r_o_item;
        n_o_length  = r_o_length;
        n_o_last    = r_o_last;
        rd_en       = 1'b0;
        rd_addr     = r_ptr[bpl_pkg::AddrW-1:0];
        wr_en       = 1'b0;
        wr_addr     = r_ptr[bpl_pkg::AddrW-1:0];
        wr_data     = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_val  = i_value;
                    n_st   = bpl_pkg::StOk;
                    n_item = '0;
                    case (i_command)
                        bpl_pkg::CmdInsFront, bpl_pkg::CmdInsPos, bpl_pkg::CmdInsEnd: begin
                            if (r_count == bpl_pkg::t_cnt'(bpl_pkg::Depth)) begin
                                n_st    = bpl_pkg::StFull;
                                n_state = S_EMIT;
                            end else begin
                                // find the gap index
                                if (i_command == bpl_pkg::CmdInsFront) begin
                                    n_idx = '0;
                                end else if (i_command == bpl_pkg::CmdInsEnd
                                             || r_count == '0) begin
                                    n_idx = r_count;
                                end else if (pos_c == '0) begin
                                    n_idx = bpl_pkg::t_cnt'(1);
                                end else if (pos_c > cnt_c) begin
                                    n_idx = r_count;
                                end else begin
                                    n_idx = bpl_pkg::t_cnt'(pos_c);
                                end
                                n_ptr   = r_count;
                                n_state = (r_count > n_idx) ? S_INS_RD : S_INS_PUT;
                            end
                        end
                        bpl_pkg::CmdDelFront, bpl_pkg::CmdDelPos, bpl_pkg::CmdDelEnd: begin
                            if (r_count == '0) begin
                                n_st    = bpl_pkg::StEmpty;
                                n_state = S_EMIT;
                            end else if (i_command == bpl_pkg::CmdDelPos
                                         && pos_c > cnt_c) begin
                                n_st    = bpl_pkg::StNotFound;
                                n_state = S_EMIT;
                            end else begin
                                if (i_command == bpl_pkg::CmdDelFront) begin
                                    n_idx = '0;
                                end else if (i_command == bpl_pkg::CmdDelEnd) begin
                                    n_idx = r_count - bpl_pkg::t_cnt'(1);
                                end else if (pos_c == '0) begin
                                    n_idx = '0;
                                end else begin
                                    n_idx = bpl_pkg::t_cnt'(pos_c - bpl_pkg::t_cmp'(1));
                                end
                                n_state = S_DEL_RD0;
                            end
                        end
                        bpl_pkg::CmdClear: begin
                            n_count = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                            // dump
                            if (r_count == '0) begin
                                n_st    = bpl_pkg::StEmpty;
                                n_state = S_EMIT;
                            end else begin
                                n_ptr   = '0;
                                n_state = S_DMP_RD;
                            end
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_dec[bpl_pkg::AddrW-1:0];
                n_state = S_INS_WR;
            end
            S_INS_WR: begin
                wr_en   = 1'b1;
                n_ptr   = ptr_dec;
                n_state = (ptr_dec > r_idx) ? S_INS_RD : S_INS_PUT;
            end
            S_INS_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx[bpl_pkg::AddrW-1:0];
                wr_data = r_val;
                n_count = r_count + bpl_pkg::t_cnt'(1);
                n_state = S_EMIT;
            end
            S_DEL_RD0: begin
                rd_en   = 1'b1;
                rd_addr = r_idx[bpl_pkg::AddrW-1:0];
                n_ptr   = r_idx;
                n_state = S_DEL_CAP;
            end
            S_DEL_CAP: begin
                n_item  = r_rdata;
                n_state = (ptr_inc < r_count) ? S_DEL_RD : S_DEL_END;
            end
            S_DEL_RD: begin
                rd_en   = 1'b1;
                rd_addr = ptr_inc[bpl_pkg::AddrW-1:0];
                n_state = S_DEL_WR;
            end
            S_DEL_WR: begin
                wr_en   = 1'b1;
                n_ptr   = ptr_inc;
                n_state = ((ptr_inc + bpl_pkg::t_cnt'(1)) < r_count) ? S_DEL_RD : S_DEL_END;
            end
            S_DEL_END: begin
                n_count = r_count - bpl_pkg::t_cnt'(1);
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_st;
                    n_o_item    = r_item;
                    n_o_length  = bpl_pkg::t_len'(r_count);
                    n_o_last    = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DMP_RD: begin
                rd_en   = 1'b1;
                n_state = S_DMP_WAIT;
            end
            S_DMP_WAIT: begin
                // read data holds until the output register frees up
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = bpl_pkg::StOk;
                    n_o_item    = r_rdata;
                    n_o_length  = bpl_pkg::t_len'(r_count);
                    n_o_last    = (ptr_inc == r_count);
                    n_ptr       = ptr_inc;
                    n_state     = (ptr_inc == r_count) ? S_IDLE : S_DMP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_val      <= n_val;
        r_st       <= n_st;
        r_item     <= n_item;
        r_o_status <= n_o_status;
        r_o_item   <= n_o_item;
        r_o_length <= n_o_length;
        r_o_last   <= n_o_last;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
